>>> hdl/p2p_pkg.sv
// ----------------------------------------------------------------------------
// p2p_pkg
// Types, codes and constants shared by the receive engine's front, queue
// and back.
// ----------------------------------------------------------------------------
package p2p_pkg;

  localparam int QUEUE_DEPTH = 2;

  // packet commands
  localparam logic [15:0] CMD_DATA  = 16'd61904;
  localparam logic [15:0] CMD_READY = 16'd61762;
  localparam logic [15:0] CMD_ALIVE = 16'd61920;
  localparam logic [15:0] CMD_CLOSE = 16'd61936;

  localparam logic [15:0] CTL_CONNECT_ACK = 16'h2011;
  localparam logic [31:0] FRAME_MARK      = 32'h55AA15A8;
  localparam logic [31:0] JPEG_MARK       = 32'hFFD8FFDB;
  localparam logic [31:0] TICKET_FLIP     = 32'h01010101;

  localparam logic [7:0] CHAN_CONTROL = 8'd0;
  localparam logic [7:0] CHAN_DATA    = 8'd1;
  localparam logic [7:0] MEDIA_VIDEO  = 8'd3;

  localparam logic [15:0] MIN_MSG_LEN  = 16'd4;
  localparam logic [15:0] MIN_BODY_LEN = 16'd12;
  localparam logic [15:0] MARK_HDR_LEN = 16'd36;
  localparam logic [15:0] JPEG_HDR_LEN = 16'd4;
  localparam logic [15:0] CTL_HDR_LEN  = 16'd20;
  localparam logic [15:0] MIN_TICKET_PAYLOAD = 16'd12;

  localparam logic [5:0] OFFSET_MARK = 6'd40;
  localparam logic [5:0] OFFSET_DATA = 6'd8;

  // reply kinds
  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_CHECK = 2'd1;
  localparam logic [1:0] REPLY_ALIVE = 2'd2;
  localparam logic [1:0] REPLY_ACK   = 2'd3;

  // frame actions
  localparam logic [2:0] FA_NONE     = 3'd0;
  localparam logic [2:0] FA_START    = 3'd1;
  localparam logic [2:0] FA_APPEND   = 3'd2;
  localparam logic [2:0] FA_DROP_OLD = 3'd3;
  localparam logic [2:0] FA_DROP_GAP = 3'd4;

  // operations handed from front to back
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_SEQ   = 2'd2;
  localparam logic [1:0] OP_LOGIN = 2'd3;

  typedef struct packed {
    logic [15:0] msg_len;
    logic [15:0] command;
    logic [7:0]  channel;
    logic [15:0] body_len;
    logic [15:0] seq_id;
    logic [31:0] magic_word;
    logic [7:0]  media_type;
    logic [15:0] control_cmd;
    logic [15:0] payload_size;
    logic [31:0] ticket_raw;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [7:0]  ack_channel;
    logic [15:0] ack_seq;
    logic [2:0]  frame_action;
    logic [5:0]  data_offset;
    logic [15:0] take_len;
    logic        emit_prev_frame;
    logic        login;
    logic [31:0] ticket;
    logic        disconnect;
  } dec_item_t;

  // classified item waiting for the back end
  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [7:0]  ack_channel;
    logic [15:0] ack_seq;
    logic        disconnect;
    logic [1:0]  op;
    logic [5:0]  data_offset;
    logic [15:0] take_len;
    logic [15:0] seq_id;
    logic [31:0] ticket_new;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hdl/p2p_front.sv
// ----------------------------------------------------------------------------
// p2p_front
// Classifies one received header summary: reply kind, echo fields and the
// operation the back end carries out on the stream state.
// ----------------------------------------------------------------------------
module p2p_front (
  input  p2p_pkg::rx_item_t rx,
  output p2p_pkg::cls_t     cls
);
  import p2p_pkg::*;

  logic [15:0] plen;

  // clamp the control payload length to the datagram
  assign plen = (rx.msg_len > CTL_HDR_LEN && rx.payload_size > rx.msg_len) ?
                (rx.msg_len - CTL_HDR_LEN) : rx.payload_size;

  always_comb begin
    cls = '0;
    cls.seq_id     = rx.seq_id;
    cls.ticket_new = rx.ticket_raw ^ TICKET_FLIP;
    if (rx.msg_len >= MIN_MSG_LEN) begin
      unique case (rx.command)
        CMD_READY: cls.reply_kind = REPLY_CHECK;
        CMD_ALIVE: cls.reply_kind = REPLY_ALIVE;
        CMD_DATA: begin
          cls.reply_kind  = REPLY_ACK;
          cls.ack_channel = rx.channel;
          cls.ack_seq     = rx.seq_id;
          if (rx.channel == CHAN_DATA) begin
            if (rx.body_len >= MIN_BODY_LEN) begin
              if (rx.magic_word == FRAME_MARK) begin
                if (rx.media_type == MEDIA_VIDEO && rx.body_len > MARK_HDR_LEN) begin
                  cls.op          = OP_START;
                  cls.data_offset = OFFSET_MARK;
                  cls.take_len    = rx.body_len - MARK_HDR_LEN;
                end
              end else if (rx.magic_word == JPEG_MARK) begin
                cls.op          = OP_START;
                cls.data_offset = OFFSET_DATA;
                cls.take_len    = rx.body_len - JPEG_HDR_LEN;
              end else begin
                cls.op          = OP_SEQ;
                cls.data_offset = OFFSET_DATA;
                cls.take_len    = rx.body_len - JPEG_HDR_LEN;
              end
            end
          end else if (rx.channel == CHAN_CONTROL) begin
            if (rx.control_cmd == CTL_CONNECT_ACK && plen >= MIN_TICKET_PAYLOAD) begin
              cls.op = OP_LOGIN;
            end
          end
        end
        CMD_CLOSE: begin
          cls.reply_kind  = REPLY_ACK;
          cls.ack_channel = rx.channel;
          cls.ack_seq     = rx.seq_id;
          cls.disconnect  = 1'b1;
        end
        default: cls.reply_kind = REPLY_NONE;
      endcase
    end
  end

endmodule

>>> hdl/p2p_queue.sv
// ----------------------------------------------------------------------------
// p2p_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module p2p_queue #(
  parameter int DEPTH = p2p_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  p2p_pkg::cls_t    push_data,
  input  logic             pop,
  output p2p_pkg::cls_t    pop_data,
  output p2p_pkg::q_stat_t stat
);
  import p2p_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/p2p_back.sv
// ----------------------------------------------------------------------------
// p2p_back
// Applies classified items to the sequence, frame and ticket state and
// holds the decision item in the output register.
// ----------------------------------------------------------------------------
module p2p_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  p2p_pkg::cls_t      q_data,
  output logic               q_pop,
  output logic               dec_valid,
  input  logic               dec_ready,
  output p2p_pkg::dec_item_t dec_item
);
  import p2p_pkg::*;

  logic [15:0] last_seq;
  logic        frame_bad;
  logic        frame_open;
  logic [31:0] session_ticket;

  logic [15:0] last_seq_next;
  logic        frame_bad_next;
  logic        frame_open_next;
  logic [31:0] session_ticket_next;
  dec_item_t   res;
  logic [16:0] seq_plus;

  assign q_pop    = q_valid && (!dec_valid || dec_ready);
  assign seq_plus = {1'b0, last_seq} + 17'd1;

  always_comb begin
    last_seq_next       = last_seq;
    frame_bad_next      = frame_bad;
    frame_open_next     = frame_open;
    session_ticket_next = session_ticket;
    res                 = '0;
    res.reply_kind      = q_data.reply_kind;
    res.ack_channel     = q_data.ack_channel;
    res.ack_seq         = q_data.ack_seq;
    res.disconnect      = q_data.disconnect;
    unique case (q_data.op)
      OP_START: begin
        res.frame_action    = FA_START;
        res.data_offset     = q_data.data_offset;
        res.take_len        = q_data.take_len;
        res.emit_prev_frame = frame_open && !frame_bad;
        frame_bad_next      = 1'b0;
        frame_open_next     = 1'b1;
        last_seq_next       = q_data.seq_id;
      end
      OP_SEQ: begin
        if (q_data.seq_id <= last_seq) begin
          res.frame_action = FA_DROP_OLD;
        end else if ({1'b0, q_data.seq_id} > seq_plus) begin
          res.frame_action = FA_DROP_GAP;
          frame_bad_next   = 1'b1;
        end else begin
          last_seq_next = q_data.seq_id;
          if (frame_open) begin
            res.frame_action = FA_APPEND;
            res.data_offset  = q_data.data_offset;
            res.take_len     = q_data.take_len;
          end
        end
      end
      OP_LOGIN: begin
        res.login           = 1'b1;
        session_ticket_next = q_data.ticket_new;
      end
      default: res.frame_action = FA_NONE;
    endcase
    res.ticket = session_ticket_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq       <= '0;
      frame_bad      <= 1'b0;
      frame_open     <= 1'b0;
      session_ticket <= '0;
      dec_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        last_seq       <= last_seq_next;
        frame_bad      <= frame_bad_next;
        frame_open     <= frame_open_next;
        session_ticket <= session_ticket_next;
        dec_valid      <= 1'b1;
      end else if (dec_ready) begin
        dec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dec_item <= res;
    end
  end

endmodule

>>> hdl/p2p_packet_receive_engine.sv
// ----------------------------------------------------------------------------
// p2p_packet_receive_engine
// Receive decision engine: one header summary in, one decision item out.
// ----------------------------------------------------------------------------
// Usage:
//   rx_valid/rx_ready/rx_item carry one header summary per received
//   datagram. dec_valid/dec_ready/dec_item carry the decision for it:
//   reply kind and echo fields, frame reassembly action, login and ticket,
//   and disconnect. Every input item gives exactly one decision item, in order.
//   The front classifies combinationally into a QUEUE_DEPTH-entry queue
//   at the accepting edge; the back pops the item, when the output
//   register is empty or being taken, through its sequence and frame
//   state into the output register, which raises dec_valid.
//   Throughput is one item per cycle while dec_ready stays high; the back's
//   single state update per popped item sets that figure.
//   Reset empties the queue and clears dec_valid, last_seq, the frame flags
//   and the session ticket.
//   When dec_ready is low the output register holds, the queue fills, and
//   rx_ready falls once QUEUE_DEPTH items wait.
// ----------------------------------------------------------------------------
module p2p_packet_receive_engine #(
  parameter int QUEUE_DEPTH = p2p_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  p2p_pkg::rx_item_t  rx_item,
  output logic               dec_valid,
  input  logic               dec_ready,
  output p2p_pkg::dec_item_t dec_item
);
  import p2p_pkg::*;

  cls_t    cls;
  cls_t    q_data;
  q_stat_t q_stat;
  logic    q_pop;
  logic    push;

  assign rx_ready = !q_stat.full;
  assign push     = rx_valid && rx_ready;

  p2p_front u_front (
    .rx  (rx_item),
    .cls (cls)
  );

  p2p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  p2p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_stat.empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_item  (dec_item)
  );

  // an accepted item is waiting in the queue on the next cycle
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_stat.empty)
    else $error("queue empty after accepted item");

  // only an acknowledge carries frame, login or close effects
  a_ack_only: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_item.reply_kind != REPLY_ACK |->
      dec_item.frame_action == FA_NONE && !dec_item.login && !dec_item.disconnect)
    else $error("stream effect without acknowledge");

  // release of the previous frame happens only on a frame start
  a_emit_on_start: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_item.emit_prev_frame |-> dec_item.frame_action == FA_START)
    else $error("frame release without frame start");

  // ticket changes between decisions only on a login
  a_ticket_login: assert property (@(posedge clk) disable iff (rst)
    q_pop && dec_valid && !$past(rst) |=>
      dec_item.login || dec_item.ticket == $past(dec_item.ticket))
    else $error("ticket changed without login");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the receive decision engine. Header summaries go in
// over a valid/ready channel with random gaps; each decision item coming out
// is compared field by field against an in-bench prediction of the reply,
// frame reassembly and login logic. Directed items cover the corner cases,
// then long random runs of frame bursts, logins and noise follow.
// ----------------------------------------------------------------------------
module testbench;
  import p2p_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1250;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_ready;
  rx_item_t  rx_item = '0;
  logic      dec_valid;
  logic      dec_ready = 1'b0;
  dec_item_t dec_item;

  // predicted engine state
  logic [15:0] trk_last_seq   = '0;
  logic        trk_frame_bad  = 1'b0;
  logic        trk_frame_open = 1'b0;
  logic [31:0] trk_ticket     = '0;

  dec_item_t decisions_due[$];

  int n_sent = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_start = 0;
  int n_release = 0;
  int n_append = 0;
  int n_drop = 0;
  int n_login = 0;
  int stuck_cycles = 0;
  int idle_pct = 0;
  bit hold_req = 1'b0;

  p2p_packet_receive_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_item   (rx_item),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_item  (dec_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the decision for one accepted header summary and advance state.
  function automatic dec_item_t rx_decision(input rx_item_t it);
    dec_item_t   d;
    logic        st;
    logic [5:0]  st_off;
    logic [15:0] st_len;
    logic [15:0] plen;
    d = '0;
    st = 1'b0;
    st_off = '0;
    st_len = '0;
    if (it.msg_len >= MIN_MSG_LEN) begin
      case (it.command)
        CMD_READY: d.reply_kind = REPLY_CHECK;
        CMD_ALIVE: d.reply_kind = REPLY_ALIVE;
        CMD_DATA, CMD_CLOSE: begin
          d.reply_kind  = REPLY_ACK;
          d.ack_channel = it.channel;
          d.ack_seq     = it.seq_id;
          d.disconnect  = (it.command == CMD_CLOSE);
          if (it.command == CMD_DATA && it.channel == CHAN_DATA &&
              it.body_len >= MIN_BODY_LEN) begin
            if (it.magic_word == FRAME_MARK) begin
              if (it.media_type == MEDIA_VIDEO && it.body_len > MARK_HDR_LEN) begin
                st = 1'b1;
                st_off = OFFSET_MARK;
                st_len = it.body_len - MARK_HDR_LEN;
              end
            end else if (it.magic_word == JPEG_MARK) begin
              st = 1'b1;
              st_off = OFFSET_DATA;
              st_len = it.body_len - JPEG_HDR_LEN;
            end else if (it.seq_id <= trk_last_seq) begin
              d.frame_action = FA_DROP_OLD;
              n_drop++;
            end else if ({1'b0, it.seq_id} > {1'b0, trk_last_seq} + 17'd1) begin
              trk_frame_bad = 1'b1;
              d.frame_action = FA_DROP_GAP;
              n_drop++;
            end else begin
              trk_last_seq = it.seq_id;
              if (trk_frame_open) begin
                d.frame_action = FA_APPEND;
                d.data_offset  = OFFSET_DATA;
                d.take_len     = it.body_len - JPEG_HDR_LEN;
                n_append++;
              end
            end
            if (st) begin
              d.frame_action    = FA_START;
              d.data_offset     = st_off;
              d.take_len        = st_len;
              d.emit_prev_frame = trk_frame_open && !trk_frame_bad;
              trk_frame_bad  = 1'b0;
              trk_frame_open = 1'b1;
              trk_last_seq   = it.seq_id;
              n_start++;
              if (d.emit_prev_frame) n_release++;
            end
          end else if (it.command == CMD_DATA && it.channel == CHAN_CONTROL) begin
            plen = it.payload_size;
            // clamp a payload length that runs past the datagram
            if (it.msg_len > CTL_HDR_LEN && plen > it.msg_len) plen = it.msg_len - CTL_HDR_LEN;
            if (it.control_cmd == CTL_CONNECT_ACK && plen >= MIN_TICKET_PAYLOAD) begin
              trk_ticket = it.ticket_raw ^ TICKET_FLIP;
              d.login = 1'b1;
              n_login++;
            end
          end
        end
        default: ;
      endcase
    end
    d.ticket = trk_ticket;
    return d;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic rx_item_t noise_item();
    rx_item_t it;
    it.msg_len      = 16'($urandom);
    it.command      = 16'($urandom);
    it.channel      = 8'($urandom);
    it.body_len     = 16'($urandom);
    it.seq_id       = 16'($urandom);
    it.magic_word   = 32'($urandom);
    it.media_type   = 8'($urandom);
    it.control_cmd  = 16'($urandom);
    it.payload_size = 16'($urandom);
    it.ticket_raw   = 32'($urandom);
    return it;
  endfunction

  function automatic rx_item_t pkt(input logic [15:0] cmd, input logic [7:0] chan);
    rx_item_t it;
    it = noise_item();
    it.msg_len = 16'($urandom_range(MIN_MSG_LEN, 65535));
    it.command = cmd;
    it.channel = chan;
    return it;
  endfunction

  function automatic rx_item_t video(input logic [15:0] id, input logic [15:0] blen,
                                     input logic [31:0] magic, input logic [7:0] mtype);
    rx_item_t it;
    it = pkt(CMD_DATA, CHAN_DATA);
    it.seq_id     = id;
    it.body_len   = blen;
    it.magic_word = magic;
    it.media_type = mtype;
    return it;
  endfunction

  function automatic rx_item_t ctl(input logic [15:0] mlen, input logic [15:0] ccmd,
                                   input logic [15:0] psize, input logic [31:0] raw);
    rx_item_t it;
    it = pkt(CMD_DATA, CHAN_CONTROL);
    it.msg_len      = mlen;
    it.control_cmd  = ccmd;
    it.payload_size = psize;
    it.ticket_raw   = raw;
    return it;
  endfunction

  function automatic logic [15:0] body_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'($urandom_range(0, MIN_BODY_LEN - 1));
    if (r < 90) return 16'($urandom_range(MIN_BODY_LEN, 1500));
    return 16'($urandom);
  endfunction

  // Offer one item, hold it until accepted, and queue its decision.
  task automatic send_rx(input rx_item_t it);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? idle_len() : 0;
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_item  <= it;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    decisions_due.push_back(rx_decision(it));
    n_sent++;
  endtask

  task automatic report(input string msg);
    n_err++;
    if (n_err <= 40) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("decision %0d %s: got 0x%0h, want 0x%0h", n_checked, name, got, want));
  endtask

  // Receiver pacing: random stalls, or one long hold on request.
  initial begin : sink_pacing
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        dec_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        dec_ready <= 1'b0;
        n = idle_len();
        repeat (n) @(posedge clk);
      end
      dec_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : decision_check
    dec_item_t want;
    if (!rst && dec_valid && dec_ready) begin
      if (decisions_due.size() == 0) begin
        report($sformatf("decision %0d arrived with none outstanding", n_checked));
      end else begin
        want = decisions_due.pop_front();
        check_field("reply_kind", 32'(dec_item.reply_kind), 32'(want.reply_kind));
        check_field("ack_channel", 32'(dec_item.ack_channel), 32'(want.ack_channel));
        check_field("ack_seq", 32'(dec_item.ack_seq), 32'(want.ack_seq));
        check_field("frame_action", 32'(dec_item.frame_action), 32'(want.frame_action));
        check_field("data_offset", 32'(dec_item.data_offset), 32'(want.data_offset));
        check_field("take_len", 32'(dec_item.take_len), 32'(want.take_len));
        check_field("emit_prev_frame", 32'(dec_item.emit_prev_frame),
                    32'(want.emit_prev_frame));
        check_field("login", 32'(dec_item.login), 32'(want.login));
        check_field("ticket", dec_item.ticket, want.ticket);
        check_field("disconnect", 32'(dec_item.disconnect), 32'(want.disconnect));
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (rx_valid && rx_ready) || (dec_valid && dec_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d decisions outstanding",
                 STUCK_LIMIT, decisions_due.size());
        $display("FAIL p2p_packet_receive_engine");
        $finish;
      end
    end
  end

  // Short datagrams, each reply kind, unknown commands, foreign streams.
  task automatic test_replies();
    rx_item_t it;
    it = '0;
    send_rx(it);
    it = pkt(CMD_DATA, CHAN_DATA);
    it.msg_len = MIN_MSG_LEN - 16'd1;
    send_rx(it);
    it = pkt(CMD_READY, 8'($urandom));
    it.msg_len = MIN_MSG_LEN;
    send_rx(it);
    send_rx(pkt(CMD_ALIVE, 8'($urandom)));
    send_rx(pkt(CMD_CLOSE, 8'hFF));
    it = '1;
    send_rx(it);
    send_rx(pkt(CMD_DATA, 8'd7));
  endtask

  // Frame reassembly: markers, appends, old ids, gaps, release, top id.
  task automatic test_frames();
    send_rx(video(16'd1, 16'd200, 32'h0, 8'd0));
    send_rx(video(16'd2, MIN_BODY_LEN - 16'd1, FRAME_MARK, MEDIA_VIDEO));
    send_rx(video(16'd10, 16'd300, FRAME_MARK, 8'd2));
    send_rx(video(16'd10, MARK_HDR_LEN, FRAME_MARK, MEDIA_VIDEO));
    send_rx(video(16'd10, MARK_HDR_LEN + 16'd1, FRAME_MARK, MEDIA_VIDEO));
    send_rx(video(16'd11, MIN_BODY_LEN, 32'h0, 8'd0));
    send_rx(video(16'd11, 16'd100, 32'h0, 8'd0));
    send_rx(video(16'd14, 16'd100, 32'h0, 8'd0));
    send_rx(video(16'd12, 16'd100, 32'h0, 8'd0));
    send_rx(video(16'd100, 16'd500, JPEG_MARK, 8'd0));
    send_rx(video(16'd101, 16'd500, 32'h0, 8'd0));
    send_rx(video(16'hFFFF, 16'hFFFF, JPEG_MARK, 8'hFF));
    send_rx(video(16'd0, 16'd100, 32'h0, 8'd0));
    send_rx(video(16'hFFFF, 16'd100, 32'hFFFF_FFFF, 8'd0));
  endtask

  // Connect acknowledge: payload threshold and clamp against the length.
  task automatic test_login();
    send_rx(ctl(16'd100, CTL_CONNECT_ACK, MIN_TICKET_PAYLOAD, 32'hFFFF_FFFF));
    send_rx(ctl(16'd100, CTL_CONNECT_ACK, MIN_TICKET_PAYLOAD - 16'd1, 32'h1234_5678));
    send_rx(ctl(16'd31, CTL_CONNECT_ACK, 16'd40, 32'hA5A5_A5A5));
    send_rx(ctl(16'd32, CTL_CONNECT_ACK, 16'd40, 32'h0000_0000));
    send_rx(ctl(CTL_HDR_LEN, CTL_CONNECT_ACK, 16'hFFFF, 32'h0F0F_0F0F));
    send_rx(ctl(16'hFFFF, CTL_CONNECT_ACK + 16'd1, 16'hFFFF, 32'hDEAD_BEEF));
  endtask

  // Stall the receiver long enough that the queue fills and rx_ready drops.
  task automatic test_backpressure();
    int k;
    idle_pct = 0;
    hold_req = 1'b1;
    for (k = 0; k < 20; k++) send_rx(video(16'(k + 200), body_size(), 32'h0, 8'd0));
  endtask

  // Mostly frame bursts with random content, plus logins, replies and noise.
  task automatic test_random_traffic(input int n_goal);
    int          sent;
    int          k;
    int          burst;
    int          r;
    logic [15:0] last;
    rx_item_t    it;
    sent = 0;
    while (sent < n_goal) begin
      case (sent * 4 / n_goal)
        0: idle_pct = 0;
        1: idle_pct = 20;
        2: idle_pct = 50;
        default: idle_pct = 10;
      endcase
      r = $urandom_range(0, 99);
      if (r < 60) begin
        last = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65528, 65535))
                                           : 16'($urandom);
        it = video(last, body_size(), JPEG_MARK, 8'($urandom));
        if ($urandom_range(0, 1)) begin
          it.magic_word = FRAME_MARK;
          it.media_type = ($urandom_range(0, 7) == 0) ? 8'($urandom) : MEDIA_VIDEO;
        end
        send_rx(it);
        sent++;
        burst = $urandom_range(1, 12);
        for (k = 0; k < burst; k++) begin
          it = video(last + 16'd1, body_size(), 32'($urandom), 8'($urandom));
          r = $urandom_range(0, 99);
          if (r < 8) it.seq_id = last + 16'($urandom_range(2, 5));
          else if (r >= 92) it.seq_id = last - 16'($urandom_range(0, 3));
          else if (it.body_len >= MIN_BODY_LEN) last = last + 16'd1;
          send_rx(it);
          sent++;
        end
      end else if (r < 75) begin
        it = ctl(($urandom_range(0, 1) ? 16'($urandom_range(4, 40)) : 16'($urandom)),
                 ($urandom_range(0, 3) != 0) ? CTL_CONNECT_ACK : 16'($urandom),
                 ($urandom_range(0, 1) ? 16'($urandom_range(0, 24)) : 16'($urandom)),
                 32'($urandom));
        send_rx(it);
        sent++;
      end else if (r < 88) begin
        case ($urandom_range(0, 3))
          0: it = pkt(CMD_READY, 8'($urandom));
          1: it = pkt(CMD_ALIVE, 8'($urandom));
          2: it = pkt(CMD_CLOSE, 8'($urandom));
          default: it = pkt(CMD_DATA, 8'($urandom_range(2, 255)));
        endcase
        send_rx(it);
        sent++;
      end else begin
        it = noise_item();
        if ($urandom_range(0, 9) < 3) it.msg_len = 16'($urandom_range(0, MIN_MSG_LEN - 1));
        send_rx(it);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_replies();
    test_frames();
    test_login();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    rx_valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d header summaries, checked %0d decisions, %0d mismatches",
             n_sent, n_checked, n_err);
    $display("frames: %0d starts (%0d released a good frame), %0d appends, %0d drops; %0d logins",
             n_start, n_release, n_append, n_drop, n_login);
    if (n_err == 0) begin
      $display("PASS p2p_packet_receive_engine");
    end else begin
      $display("FAIL p2p_packet_receive_engine");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/p2p_pkg.sv
hdl/p2p_front.sv
hdl/p2p_queue.sv
hdl/p2p_back.sv
hdl/p2p_packet_receive_engine.sv
tb/sv/testbench.sv
